### hw/rtl/sbs_pkg.sv
// Shared types and constants for the string byte sorter.
// Holds the input and result item structs and the queue entry format.
// No dependencies.
`timescale 1ns / 1ps

package sbs_pkg;

    // One input item: a character byte and the end-of-string flag.
    typedef struct packed {
        logic [7:0] char_in;
        logic       last_in;
    } sbs_in_t;

    // One result item: a sorted byte with its end and truncation flags.
    typedef struct packed {
        logic [7:0] char_out;
        logic       last_out;
        logic       truncated;
    } sbs_out_t;

    // Classified item as it travels from the front end to the sort engine.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       keep;
    } sbs_entry_t;

    // Depth of the queue between front end and sort engine.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

endpackage

### hw/rtl/sbs_front.sv
// Front end of the string byte sorter: accepts input items and marks each
// byte as kept or dropped against the string capacity. Depends on sbs_pkg.
`timescale 1ns / 1ps

module sbs_front
    import sbs_pkg::*;
#(
    parameter int MAX_LEN = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  sbs_in_t    in_data,
    output logic       push_valid,
    input  logic       push_ready,
    output sbs_entry_t push_data
);

    localparam int CW = $clog2(MAX_LEN + 1);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          keep;
    logic          accept;

    // The front end passes items straight into the queue.
    assign in_ready   = push_ready;
    assign push_valid = in_valid;
    assign accept     = in_valid && push_ready;
    assign keep       = count_reg < CW'(MAX_LEN);

    assign push_data.data = in_data.char_in;
    assign push_data.last = in_data.last_in;
    assign push_data.keep = keep;

    // Count stored bytes of the current string; restart after the last one.
    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            if (in_data.last_in)
            begin
                count_next = '0;
            end
            else if (keep)
            begin
                count_next = count_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

### hw/rtl/sbs_queue.sv
// Small FIFO between the front end and the sort engine of the string byte
// sorter. Depends on sbs_pkg for the entry type and depth.
`timescale 1ns / 1ps

module sbs_queue
    import sbs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push_valid,
    output logic       push_ready,
    input  sbs_entry_t push_data,
    output logic       pop_valid,
    input  logic       pop_ready,
    output sbs_entry_t pop_data
);

    sbs_entry_t          mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_CW-1:0] count_reg;
    logic                push;
    logic                pop;

    assign push_ready = count_reg != QUEUE_CW'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = mem[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + QUEUE_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + QUEUE_AW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + QUEUE_CW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - QUEUE_CW'(1);
            end
        end
    end

    // Occupancy grows by one on a lone push.
    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + QUEUE_CW'(1))
        else $error("queue count did not grow on push");

    // Occupancy shrinks by one on a lone pop.
    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> count_reg == $past(count_reg) - QUEUE_CW'(1))
        else $error("queue count did not shrink on pop");

    // The head entry holds while it waits to be taken.
    a_head_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (pop_valid && !pop_ready) |=> pop_valid && $stable(pop_data))
        else $error("queue head changed before it was taken");

endmodule

### hw/rtl/sbs_back.sv
// Sort engine of the string byte sorter: an insertion cell chain that keeps
// the bytes of one string in order and then shifts them out through an
// output register. Depends on sbs_pkg.
`timescale 1ns / 1ps

module sbs_back
    import sbs_pkg::*;
#(
    parameter int MAX_LEN = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       pop_valid,
    output logic       pop_ready,
    input  sbs_entry_t pop_data,
    output logic       out_valid,
    input  logic       out_ready,
    output sbs_out_t   out_data
);

    typedef enum logic {
        ST_FILL,
        ST_DRAIN
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic               ovf_reg;
    logic               ovf_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    sbs_out_t           out_data_reg;
    sbs_out_t           out_data_next;

    logic [7:0]         cell_val_reg   [MAX_LEN];
    logic [MAX_LEN-1:0] cell_valid_reg;
    logic [7:0]         ins_val        [MAX_LEN];
    logic [MAX_LEN-1:0] ins_valid;
    logic [MAX_LEN-1:0] le;

    logic               pop;
    logic               insert;
    logic               load;
    logic               final_byte;

    assign pop_ready  = state_reg == ST_FILL;
    assign pop        = pop_valid && pop_ready;
    assign insert     = pop && pop_data.keep;
    assign load       = (state_reg == ST_DRAIN) && (!out_valid_reg || out_ready);
    assign final_byte = !cell_valid_reg[1];

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Each cell compares its byte with the incoming one; the chain stays
    // sorted ascending, so the cells at or below the new byte form a prefix.
    always_comb
    begin
        for (int i = 0; i < MAX_LEN; i++)
        begin
            le[i] = cell_valid_reg[i] && (cell_val_reg[i] <= pop_data.data);
        end
        ins_val[0]   = le[0] ? cell_val_reg[0] : pop_data.data;
        ins_valid[0] = 1'b1;
        for (int i = 1; i < MAX_LEN; i++)
        begin
            ins_val[i]   = le[i]   ? cell_val_reg[i]   :
                           le[i-1] ? pop_data.data     : cell_val_reg[i-1];
            ins_valid[i] = cell_valid_reg[i] || cell_valid_reg[i-1];
        end
    end

    // Cell chain: insert while filling, shift toward cell 0 while draining.
    always_ff @(posedge clk)
    begin
        if (insert)
        begin
            for (int i = 0; i < MAX_LEN; i++)
            begin
                cell_val_reg[i] <= ins_val[i];
            end
        end
        else if (load)
        begin
            for (int i = 0; i < MAX_LEN - 1; i++)
            begin
                cell_val_reg[i] <= cell_val_reg[i+1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_valid_reg <= '0;
        end
        else if (insert)
        begin
            cell_valid_reg <= ins_valid;
        end
        else if (load)
        begin
            cell_valid_reg <= {1'b0, cell_valid_reg[MAX_LEN-1:1]};
        end
    end

    // Control: take items until the last one, then emit the sorted string.
    always_comb
    begin
        state_next     = state_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_FILL:
            begin
                if (pop)
                begin
                    if (!pop_data.keep)
                    begin
                        ovf_next = 1'b1;
                    end
                    if (pop_data.last)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (load)
                begin
                    out_valid_next          = 1'b1;
                    out_data_next.char_out  = cell_val_reg[0];
                    out_data_next.last_out  = final_byte;
                    out_data_next.truncated = final_byte && ovf_reg;
                    if (final_byte)
                    begin
                        state_next = ST_FILL;
                        ovf_next   = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_FILL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FILL;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    // While draining there is always a byte left in the chain.
    a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |-> cell_valid_reg[0])
        else $error("drain with an empty cell chain");

    // A kept byte never arrives when the chain is full.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        insert |-> !cell_valid_reg[MAX_LEN-1])
        else $error("insert into a full cell chain");

    // After the final byte is loaded the chain is empty.
    a_empty_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (load && final_byte) |=> !cell_valid_reg[0])
        else $error("cell chain not empty after final byte");

endmodule

### hw/rtl/string_byte_sorter.sv
// Top level of the string byte sorter: front end, queue and sort engine.
// Depends on sbs_pkg, sbs_front, sbs_queue and sbs_back.
`timescale 1ns / 1ps

// The sorter takes a string one byte per item, with last_in on the final
// byte, and returns the same bytes in ascending unsigned order, last_out on
// the final one and truncated set there if more than MAX_LEN bytes came in
// (the extra bytes are dropped). Input items are accepted one per cycle
// while the queue has room; each byte is inserted into its sorted place in
// a chain of MAX_LEN compare cells. After the last byte, a string of n
// stored bytes leaves through the output register at one item per cycle
// while out_ready allows, as the chain shifts toward its head. A four-item
// queue sits between the front end and the cell chain, so bytes of the next
// string are taken while the previous one drains, until that queue is full.

module string_byte_sorter
    import sbs_pkg::*;
#(
    parameter int MAX_LEN = 32
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  sbs_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output sbs_out_t out_data
);

    logic       push_valid;
    logic       push_ready;
    sbs_entry_t push_data;
    logic       pop_valid;
    logic       pop_ready;
    sbs_entry_t pop_data;

    // Classify each byte against the capacity.
    sbs_front #(
        .MAX_LEN (MAX_LEN)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // Decouple the front end from the sort engine.
    sbs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Sort and emit.
    sbs_back #(
        .MAX_LEN (MAX_LEN)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
